// ===== design/set_operation_engine_core_defines.svh =====
// Assertion macros used by the checker file of the set operation engine.
// Depends on nothing; expects signals clk and rst in the using scope.
`ifndef SET_OPERATION_ENGINE_CORE_DEFINES_SVH
`define SET_OPERATION_ENGINE_CORE_DEFINES_SVH

// checked outside reset
`define SOE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define SOE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/soe_pkg.sv =====
// Package for the set operation engine: sizes, codes, payload and control types.
// No dependencies.
package soe_pkg;

  localparam int SET_CAP = 16;
  localparam int CNT_W   = $clog2(SET_CAP + 1);
  localparam int IDX_W   = (SET_CAP > 1) ? $clog2(SET_CAP) : 1;
  localparam int DATA_W  = 32;

  typedef enum logic [1:0] {
    FUNC_LOAD_A = 2'd0,
    FUNC_LOAD_B = 2'd1,
    FUNC_RUN    = 2'd2,
    FUNC_CLEAR  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    OP_UNION   = 2'd0,
    OP_INTER   = 2'd1,
    OP_DIFF    = 2'd2,
    OP_SYMDIFF = 2'd3
  } op_mode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_HOLD,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_DECIDE,
    S_FLUSH
  } state_t;

  typedef struct packed {
    func_t                     func;
    logic signed [DATA_W-1:0]  element;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]  result_value;
    logic                      last;
    logic                      empty_res;
    logic                      overflowed;
  } out_item_t;

  typedef struct packed {
    logic              clr;
    logic              wr;
    logic [IDX_W-1:0]  rd_addr;
  } store_ctl_t;

endpackage

// ===== design/soe_store.sv =====
// One set store: element memory with registered read port and fill count.
// Depends on soe_pkg.
module soe_store (
  input  logic                         clk,
  input  logic                         rst,
  input  soe_pkg::store_ctl_t          ctl,
  input  logic [soe_pkg::DATA_W-1:0]   wr_data,
  output logic [soe_pkg::DATA_W-1:0]   rd_data,
  output logic [soe_pkg::CNT_W-1:0]    count
);
  import soe_pkg::*;

  logic [DATA_W-1:0] mem [SET_CAP];
  logic              full;

  assign full = (count >= CNT_W'(SET_CAP));

  always_ff @(posedge clk) begin
    if (ctl.wr && !full) begin
      mem[count[IDX_W-1:0]] <= wr_data;
    end
    rd_data <= mem[ctl.rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.clr) begin
      count <= '0;
    end else if (ctl.wr && !full) begin
      count <= count + CNT_W'(1);
    end
  end

endmodule

// ===== design/soe_seq.sv =====
// Sequencer: load/clear decode, membership scan with one shared comparator,
// result holding stage and output register. Depends on soe_pkg.
module soe_seq (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  soe_pkg::in_item_t            in_item,
  output logic                         out_valid,
  input  logic                         out_ready,
  output soe_pkg::out_item_t           out_item,
  input  logic                         cfg_wr_en,
  input  logic [1:0]                   cfg_wr_data,
  output soe_pkg::store_ctl_t          a_ctl,
  output soe_pkg::store_ctl_t          b_ctl,
  input  logic [soe_pkg::DATA_W-1:0]   a_rd,
  input  logic [soe_pkg::DATA_W-1:0]   b_rd,
  input  logic [soe_pkg::CNT_W-1:0]    cnt_a,
  input  logic [soe_pkg::CNT_W-1:0]    cnt_b
);
  import soe_pkg::*;

  state_t            state, state_next;
  op_mode_t          op_mode;
  logic              ovf;
  logic              phase;
  logic [CNT_W-1:0]  i, j;
  logic              found;
  logic [DATA_W-1:0] cur;
  logic              pend_valid;
  logic [DATA_W-1:0] pend_val;

  logic              in_fire, out_free, emit_sel, two_pass, outer_more, blocked;
  logic [CNT_W-1:0]  cnt_outer, cnt_inner;
  logic [DATA_W-1:0] rd_outer, rd_inner;

  assign in_ready  = (state == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign cnt_outer = phase ? cnt_b : cnt_a;
  assign cnt_inner = phase ? cnt_a : cnt_b;
  assign rd_outer  = phase ? b_rd : a_rd;
  assign rd_inner  = phase ? a_rd : b_rd;
  assign two_pass  = (op_mode == OP_UNION) || (op_mode == OP_SYMDIFF);
  assign outer_more = (i < cnt_outer);
  assign blocked   = emit_sel && pend_valid && !out_free;

  always_comb begin
    if (phase) begin
      emit_sel = !found;
    end else begin
      unique case (op_mode)
        OP_UNION:   emit_sel = 1'b1;
        OP_INTER:   emit_sel = found;
        OP_DIFF,
        OP_SYMDIFF: emit_sel = !found;
        default:    emit_sel = 1'b0;
      endcase
    end
  end

  always_comb begin
    a_ctl.clr     = in_fire && (in_item.func == FUNC_CLEAR);
    b_ctl.clr     = in_fire && (in_item.func == FUNC_CLEAR);
    a_ctl.wr      = in_fire && (in_item.func == FUNC_LOAD_A);
    b_ctl.wr      = in_fire && (in_item.func == FUNC_LOAD_B);
    a_ctl.rd_addr = phase ? j[IDX_W-1:0] : i[IDX_W-1:0];
    b_ctl.rd_addr = phase ? i[IDX_W-1:0] : j[IDX_W-1:0];
    state_next    = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid && (in_item.func == FUNC_RUN)) state_next = S_FETCH;
      end
      S_FETCH: begin
        if (outer_more) begin
          state_next = S_HOLD;
        end else if (!(!phase && two_pass)) begin
          state_next = S_FLUSH;
        end
      end
      S_HOLD:     state_next = S_SCAN_RD;
      S_SCAN_RD: begin
        if (found || !(j < cnt_inner)) begin
          state_next = S_DECIDE;
        end else begin
          state_next = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: state_next = S_SCAN_RD;
      S_DECIDE: begin
        if (!blocked) state_next = S_FETCH;
      end
      S_FLUSH: begin
        if (out_free) state_next = S_IDLE;
      end
      default:    state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      op_mode    <= OP_UNION;
      ovf        <= 1'b0;
      phase      <= 1'b0;
      i          <= '0;
      j          <= '0;
      found      <= 1'b0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_wr_en) op_mode <= op_mode_t'(cfg_wr_data);
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            unique case (in_item.func)
              FUNC_LOAD_A: if (cnt_a >= CNT_W'(SET_CAP)) ovf <= 1'b1;
              FUNC_LOAD_B: if (cnt_b >= CNT_W'(SET_CAP)) ovf <= 1'b1;
              FUNC_CLEAR:  ovf <= 1'b0;
              FUNC_RUN: begin
                phase      <= 1'b0;
                i          <= '0;
                pend_valid <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        S_FETCH: begin
          if (!outer_more && !phase && two_pass) begin
            phase <= 1'b1;
            i     <= '0;
          end
        end
        S_HOLD: begin
          cur   <= rd_outer;
          j     <= '0;
          found <= 1'b0;
        end
        S_SCAN_CMP: begin
          if (rd_inner == cur) found <= 1'b1;
          j <= j + CNT_W'(1);
        end
        S_DECIDE: begin
          if (!blocked) begin
            if (emit_sel) begin
              if (pend_valid) begin
                out_item.result_value <= pend_val;
                out_item.last         <= 1'b0;
                out_item.empty_res    <= 1'b0;
                out_item.overflowed   <= ovf;
                out_valid             <= 1'b1;
              end
              pend_val   <= cur;
              pend_valid <= 1'b1;
            end
            i <= i + CNT_W'(1);
          end
        end
        S_FLUSH: begin
          if (out_free) begin
            // empty run gives one marker transfer
            out_item.result_value <= pend_valid ? pend_val : '0;
            out_item.last         <= 1'b1;
            out_item.empty_res    <= !pend_valid;
            out_item.overflowed   <= ovf;
            out_valid             <= 1'b1;
            pend_valid            <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== design/set_operation_engine_core.sv =====
// Top level of the set operation engine: two set stores and the sequencer.
// Depends on soe_pkg, soe_store, soe_seq.
//
//  channel | signals                          | transfer
//  input   | in_valid, in_ready, in_item      | in_valid & in_ready
//  output  | out_valid, out_ready, out_item   | out_valid & out_ready
//  config  | cfg_wr_en, cfg_wr_data (op_mode) | cfg_wr_en
//
// Load and clear items are accepted while idle; back-to-back loads run at one per cycle.
// A run makes one pass over set A (a second one over set B for union and symmetric
// difference); the inner scan for each outer element stops at the first match.
// The scan is paced by the one comparator and the registered read port of each store.
// in_ready stays low for the whole run; a held output register stalls emission.
// Reset (synchronous) empties both sets, clears the overflow flag and op_mode.
module set_operation_engine_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  soe_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output soe_pkg::out_item_t  out_item,
  input  logic                cfg_wr_en,
  input  logic [1:0]          cfg_wr_data
);
  import soe_pkg::*;

  store_ctl_t        a_ctl, b_ctl;
  logic [DATA_W-1:0] a_rd, b_rd;
  logic [CNT_W-1:0]  cnt_a, cnt_b;

  soe_store u_store_a (
    .clk     (clk),
    .rst     (rst),
    .ctl     (a_ctl),
    .wr_data (in_item.element),
    .rd_data (a_rd),
    .count   (cnt_a)
  );

  soe_store u_store_b (
    .clk     (clk),
    .rst     (rst),
    .ctl     (b_ctl),
    .wr_data (in_item.element),
    .rd_data (b_rd),
    .count   (cnt_b)
  );

  soe_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_item    (out_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .a_ctl       (a_ctl),
    .b_ctl       (b_ctl),
    .a_rd        (a_rd),
    .b_rd        (b_rd),
    .cnt_a       (cnt_a),
    .cnt_b       (cnt_b)
  );

endmodule

// ===== design/soe_checker.sv =====
// Port-level checks for the set operation engine, bound to the top level.
// Depends on soe_pkg and set_operation_engine_core_defines.svh.
`include "set_operation_engine_core_defines.svh"

module soe_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input soe_pkg::out_item_t  out_item
);
  import soe_pkg::*;

  property p_out_hold;
    out_valid && !out_ready |=> out_valid && $stable(out_item);
  endproperty

  property p_empty_last;
    out_valid && out_item.empty_res |-> out_item.last;
  endproperty

  property p_empty_zero;
    out_valid && out_item.empty_res |-> out_item.result_value == '0;
  endproperty

  `SOE_ASSERT(a_out_hold, p_out_hold, "output transfer dropped or changed while stalled")
  `SOE_ASSERT(a_empty_last, p_empty_last, "empty marker not last")
  `SOE_ASSERT(a_empty_zero, p_empty_zero, "empty marker with non-zero value")
  `SOE_ASSERT_ALWAYS(a_rst_idle, rst |=> !out_valid && in_ready, "not idle after reset")

endmodule

bind set_operation_engine_core soe_checker u_soe_checker (.*);
